// ===== rtl/decimal_number_list_scanner_unit_macros.svh =====
// assertion macros used by the scanner rtl
`ifndef DECIMAL_NUMBER_LIST_SCANNER_UNIT_MACROS_SVH
`define DECIMAL_NUMBER_LIST_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define DNLS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DNLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dnls_pkg.sv =====
// types and constants of the decimal number list scanner
package dnls_pkg;

  // default sizes
  localparam int MANTISSA_BITS_DEFAULT   = 64;
  localparam int FRAC_COUNT_BITS_DEFAULT = 8;
  localparam int FRAC_DIGITS_W           = 8;
  localparam int CHAR_W                  = 8;
  localparam int DIGIT_W                 = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  // decoded character
  typedef struct packed {
    logic               is_digit;
    logic               is_dot;
    logic               is_minus;
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

endpackage

// ===== rtl/dnls_char_if.sv =====
// character item channel
interface dnls_char_if;
  import dnls_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/dnls_result_if.sv =====
// result item channel
interface dnls_result_if #(
  parameter int MANTISSA_BITS = dnls_pkg::MANTISSA_BITS_DEFAULT
);
  import dnls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     has_number;
  logic                     negative;
  logic [MANTISSA_BITS-1:0] mantissa;
  logic [FRAC_DIGITS_W-1:0] frac_digits;
  logic                     coordinate_y;
  logic                     string_done;

  modport source (output valid, output has_number, output negative, output mantissa,
                  output frac_digits, output coordinate_y, output string_done,
                  input ready);
  modport sink   (input valid, input has_number, input negative, input mantissa,
                  input frac_digits, input coordinate_y, input string_done,
                  output ready);
endinterface

// ===== rtl/decimal_number_list_scanner_unit.sv =====
// top level of the decimal number list scanner
//
//   channel     dir  handshake      payload
//   char_in     in   valid/ready    char_code[7:0], end_of_text
//   result_out  out  valid/ready    has_number, negative, mantissa, frac_digits,
//                                   coordinate_y, string_done
//
// one character item per cycle while results are taken; a result leaves
// through the input register, then the state update into the result register
// the per-character loop is the mantissa times-ten-plus-digit add in the core
// a stalled result holds the core and input register; char_in.ready drops
// only while the input register is full and the result is not taken
// rst is synchronous and returns the scanner to skipping with x next
module decimal_number_list_scanner_unit #(
  parameter int MANTISSA_BITS   = dnls_pkg::MANTISSA_BITS_DEFAULT,
  parameter int FRAC_COUNT_BITS = dnls_pkg::FRAC_COUNT_BITS_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  dnls_char_if.sink     char_in,
  dnls_result_if.source result_out
);
  import dnls_pkg::*;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_eot;
  logic              advance;
  char_class_t       s1_cls;

  // input register takes an item when empty or moving on
  assign char_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      s1_char <= char_in.char_code;
      s1_eot  <= char_in.end_of_text;
    end
  end

  // decode the registered character
  dnls_classify u_classify (
    .char_code (s1_char),
    .cls       (s1_cls)
  );

  // scan state and result register
  dnls_scan_core #(
    .MANTISSA_BITS   (MANTISSA_BITS),
    .FRAC_COUNT_BITS (FRAC_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .cls        (s1_cls),
    .eot        (s1_eot),
    .advance    (advance),
    .result_out (result_out)
  );
endmodule

// ===== rtl/dnls_classify.sv =====
// character decoder: digit, point and minus detection
module dnls_classify (
  input  logic [dnls_pkg::CHAR_W-1:0] char_code,
  output dnls_pkg::char_class_t       cls
);
  import dnls_pkg::*;

  logic [CHAR_W-1:0] offset;

  // digit value is the low nibble of the offset from '0'
  assign offset = char_code - CHAR_ZERO;

  always_comb begin
    cls.is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    cls.is_dot   = (char_code == CHAR_DOT);
    cls.is_minus = (char_code == CHAR_MINUS);
    cls.digit    = offset[DIGIT_W-1:0];
  end
endmodule

// ===== rtl/dnls_scan_core.sv =====
// number scan state, digit accumulator and result register
module dnls_scan_core #(
  parameter int MANTISSA_BITS   = dnls_pkg::MANTISSA_BITS_DEFAULT,
  parameter int FRAC_COUNT_BITS = dnls_pkg::FRAC_COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  dnls_pkg::char_class_t cls,
  input  logic                  eot,
  output logic                  advance,
  dnls_result_if.source         result_out
);
  import dnls_pkg::*;

  localparam logic [FRAC_COUNT_BITS-1:0] FRAC_MAX = '1;

  // scan state
  logic                       in_number;
  logic                       sign_minus;
  logic                       dot_seen;
  logic [MANTISSA_BITS-1:0]   digit_accumulator;
  logic [FRAC_COUNT_BITS-1:0] fraction_count;
  logic                       value_parity;

  // state with this item folded in
  logic                       start_num;
  logic                       emit;
  logic                       produce;
  logic                       step;
  logic                       sign_upd;
  logic                       dot_upd;
  logic                       in_upd;
  logic [MANTISSA_BITS-1:0]   acc_x10;
  logic [MANTISSA_BITS-1:0]   acc_upd;
  logic [FRAC_COUNT_BITS-1:0] frac_upd;
  logic [FRAC_COUNT_BITS+FRAC_DIGITS_W-1:0] frac_wide;

  // pipeline moves when the result slot is free or being drained
  assign advance = !result_out.valid || result_out.ready;
  assign step    = item_valid && advance;

  // times ten plus digit as two shifted adds, wrapping at the mantissa width
  assign acc_x10 = (digit_accumulator << 3) + (digit_accumulator << 1)
                 + {{(MANTISSA_BITS-DIGIT_W){1'b0}}, cls.digit};

  // per-character update and end-of-number decision
  always_comb begin
    start_num = !in_number && (cls.is_digit || cls.is_dot || cls.is_minus);
    in_upd    = in_number || start_num;
    sign_upd  = sign_minus || (!in_number && cls.is_minus);
    dot_upd   = dot_seen || cls.is_dot;
    acc_upd   = cls.is_digit ? acc_x10 : digit_accumulator;
    frac_upd  = fraction_count;
    if (cls.is_digit && dot_seen && (fraction_count != FRAC_MAX)) begin
      frac_upd = fraction_count + 1'b1;
    end
    if (in_number) begin
      emit = !(cls.is_digit || cls.is_dot) || eot;
    end else begin
      emit = eot && start_num;
    end
    produce   = emit || eot;
    frac_wide = {{FRAC_DIGITS_W{1'b0}}, frac_upd};
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_number         <= 1'b0;
      sign_minus        <= 1'b0;
      dot_seen          <= 1'b0;
      digit_accumulator <= '0;
      fraction_count    <= '0;
      value_parity      <= 1'b0;
      result_out.valid  <= 1'b0;
    end else if (advance) begin
      result_out.valid <= step && produce;
      if (step) begin
        if (produce) begin
          in_number         <= 1'b0;
          sign_minus        <= 1'b0;
          dot_seen          <= 1'b0;
          digit_accumulator <= '0;
          fraction_count    <= '0;
          value_parity      <= eot ? 1'b0 : !value_parity;
        end else begin
          in_number         <= in_upd;
          sign_minus        <= sign_upd;
          dot_seen          <= dot_upd;
          digit_accumulator <= acc_upd;
          fraction_count    <= frac_upd;
        end
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (step && produce) begin
      result_out.has_number   <= emit;
      result_out.negative     <= emit && sign_upd;
      result_out.mantissa     <= emit ? acc_upd : '0;
      result_out.frac_digits  <= emit ? frac_wide[FRAC_DIGITS_W-1:0] : '0;
      result_out.coordinate_y <= emit && value_parity;
      result_out.string_done  <= eot;
    end
  end

`include "decimal_number_list_scanner_unit_macros.svh"

  `DNLS_ASSERT_IMPLIES(a_empty_only_at_end, result_out.valid && !result_out.has_number, result_out.string_done, "result without number not at end of string")
  `DNLS_ASSERT_IMPLIES(a_empty_is_zero, result_out.valid && !result_out.has_number, !result_out.negative && (result_out.mantissa == '0) && (result_out.frac_digits == '0) && !result_out.coordinate_y, "result without number has nonzero fields")
  `DNLS_ASSERT_NEXT(a_end_clears, step && eot, !in_number && !value_parity && (digit_accumulator == '0), "state not cleared after end of string")
  `DNLS_ASSERT_IMPLIES(a_skip_is_clear, !in_number, (digit_accumulator == '0) && (fraction_count == '0) && !dot_seen && !sign_minus, "number state left over while skipping")
  `DNLS_ASSERT_IMPLIES(a_frac_needs_dot, fraction_count != '0, dot_seen, "fraction digits counted without point")

endmodule

// ===== tb/dnls_scanner_checker.sv =====
// checker for the scanner: predicts each result from the accepted characters and compares
module dnls_scanner_checker #(
  parameter int MANTISSA_BITS   = dnls_pkg::MANTISSA_BITS_DEFAULT,
  parameter int FRAC_COUNT_BITS = dnls_pkg::FRAC_COUNT_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  dnls_char_if   ch,
  dnls_result_if res,
  output int     failures,
  output int     outstanding,
  output int     numbers_checked,
  output int     strings_checked
);
  import dnls_pkg::*;

  localparam logic [FRAC_COUNT_BITS-1:0] FRAC_MAX = {FRAC_COUNT_BITS{1'b1}};

  typedef struct packed {
    logic                     has_number;
    logic                     negative;
    logic [MANTISSA_BITS-1:0] mantissa;
    logic [FRAC_DIGITS_W-1:0] frac_digits;
    logic                     coordinate_y;
    logic                     string_done;
  } scan_result_t;

  // scanner state as predicted
  logic                       scanning_number;
  logic                       minus_seen;
  logic                       point_seen;
  logic [MANTISSA_BITS-1:0]   digits_value;
  logic [FRAC_COUNT_BITS-1:0] frac_count;
  logic                       next_is_y;

  scan_result_t expected_results[$];

  function automatic void clear_number();
    scanning_number = 1'b0;
    minus_seen      = 1'b0;
    point_seen      = 1'b0;
    digits_value    = '0;
    frac_count      = '0;
  endfunction

  function automatic void take_digit(input logic [CHAR_W-1:0] c);
    digits_value = digits_value * 10 + MANTISSA_BITS'(c - CHAR_ZERO);
    if (point_seen && frac_count < FRAC_MAX) frac_count = frac_count + 1'b1;
  endfunction

  // one character step; returns 1 when the character yields a result
  function automatic bit scan_char(input logic [CHAR_W-1:0] c, input logic eot,
                                   output scan_result_t r);
    logic is_digit;
    logic emit;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    emit     = 1'b0;
    r        = '0;
    if (!scanning_number) begin
      if (is_digit) begin
        scanning_number = 1'b1;
        take_digit(c);
      end else if (c == CHAR_DOT) begin
        scanning_number = 1'b1;
        point_seen      = 1'b1;
      end else if (c == CHAR_MINUS) begin
        scanning_number = 1'b1;
        minus_seen      = 1'b1;
      end
      emit = eot && scanning_number;
    end else begin
      if (is_digit) begin
        take_digit(c);
        emit = eot;
      end else if (c == CHAR_DOT) begin
        point_seen = 1'b1;
        emit       = eot;
      end else begin
        // any other character closes the number and is swallowed
        emit = 1'b1;
      end
    end
    if (!emit && !eot) return 1'b0;
    r.has_number   = emit;
    r.negative     = emit && minus_seen;
    r.mantissa     = emit ? digits_value : '0;
    r.frac_digits  = emit ? FRAC_DIGITS_W'(frac_count) : '0;
    r.coordinate_y = emit && next_is_y;
    r.string_done  = eot;
    if (emit) begin
      next_is_y = !next_is_y;
      clear_number();
    end
    // end of string restarts everything, pairing included
    if (eot) begin
      clear_number();
      next_is_y = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // watch both channels on the rising edge
  always @(posedge clk) begin : watch
    scan_result_t got;
    scan_result_t want;
    if (rst) begin
      clear_number();
      next_is_y = 1'b0;
      expected_results.delete();
      failures        = 0;
      numbers_checked = 0;
      strings_checked = 0;
    end else begin
      if (res.valid && res.ready) begin
        got.has_number   = res.has_number;
        got.negative     = res.negative;
        got.mantissa     = res.mantissa;
        got.frac_digits  = res.frac_digits;
        got.coordinate_y = res.coordinate_y;
        got.string_done  = res.string_done;
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          compare_field("has_number", 64'(want.has_number), 64'(got.has_number));
          compare_field("negative", 64'(want.negative), 64'(got.negative));
          compare_field("mantissa", 64'(want.mantissa), 64'(got.mantissa));
          compare_field("frac_digits", 64'(want.frac_digits), 64'(got.frac_digits));
          compare_field("coordinate_y", 64'(want.coordinate_y), 64'(got.coordinate_y));
          compare_field("string_done", 64'(want.string_done), 64'(got.string_done));
          if (want.has_number) numbers_checked++;
          if (want.string_done) strings_checked++;
        end
      end
      if (ch.valid && ch.ready) begin
        if (scan_char(ch.char_code, ch.end_of_text, want))
          expected_results = {expected_results, want};
      end
    end
    outstanding = expected_results.size();
  end
endmodule

// ===== tb/tb.sv =====
// top of the scanner testbench: clock, reset, character stimulus, result back-pressure, verdict
module tb;
  import dnls_pkg::*;

  localparam int MB            = MANTISSA_BITS_DEFAULT;
  localparam int FB            = FRAC_COUNT_BITS_DEFAULT;
  localparam int TARGET_ITEMS  = 720;
  localparam int QUIET_ITEMS   = 100;
  localparam int TAIL_CYCLES   = 12;
  localparam int LONG_FRACTION = 270;

  typedef logic [CHAR_W-1:0] text_t[$];

  logic clk;
  logic rst;
  logic quiet;
  int   gap_pct;
  int   stall_pct;
  int   items_sent;
  int   strings_sent;
  int   failures;
  int   outstanding;
  int   numbers_checked;
  int   strings_checked;

  dnls_char_if                          char_bus();
  dnls_result_if #(.MANTISSA_BITS(MB)) result_bus();

  decimal_number_list_scanner_unit #(
    .MANTISSA_BITS  (MB),
    .FRAC_COUNT_BITS(FB)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_bus),
    .result_out(result_bus)
  );

  dnls_scanner_checker #(
    .MANTISSA_BITS  (MB),
    .FRAC_COUNT_BITS(FB)
  ) chk (
    .clk            (clk),
    .rst            (rst),
    .ch             (char_bus),
    .res            (result_bus),
    .failures       (failures),
    .outstanding    (outstanding),
    .numbers_checked(numbers_checked),
    .strings_checked(strings_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result back-pressure in bursts, rate changes every so often
  initial begin : sink_side
    int left;
    result_bus.ready <= 1'b0;
    stall_pct = 10;
    left      = 40;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      @(negedge clk);
      left--;
      if (left <= 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          2:       stall_pct = 20;
          default: stall_pct = 45;
        endcase
        left = $urandom_range(20, 80);
      end
    end
  end

  // one character item, presented at the falling edge until taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eot);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    char_bus.valid       <= 1'b1;
    char_bus.char_code   <= c;
    char_bus.end_of_text <= eot;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    items_sent++;
    if (items_sent >= TARGET_ITEMS - QUIET_ITEMS) quiet = 1'b1;
    @(negedge clk);
  endtask

  // whole string, end_of_text on its last character
  task automatic send_text(input text_t txt);
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    strings_sent++;
  endtask

  // append one character to the text
  function automatic void add_char(ref text_t txt, input logic [CHAR_W-1:0] c);
    txt = {txt, c};
  endfunction

  function automatic void push_text(ref text_t txt, input string s);
    for (int i = 0; i < s.len(); i++) add_char(txt, s[i]);
  endfunction

  function automatic void push_digits(ref text_t txt, input int count);
    repeat (count) add_char(txt, CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
  endfunction

  // signed decimal with random shape; the longest integer parts wrap the mantissa
  function automatic void push_number(ref text_t txt);
    if ($urandom_range(0, 9) < 3) add_char(txt, CHAR_MINUS);
    if ($urandom_range(0, 19) == 0) push_digits(txt, $urandom_range(15, 25));
    else push_digits(txt, $urandom_range(0, 5));
    if ($urandom_range(0, 1)) begin
      add_char(txt, CHAR_DOT);
      if ($urandom_range(0, 19) == 0) add_char(txt, CHAR_DOT);
      push_digits(txt, $urandom_range(0, 8));
    end
  endfunction

  // list of points, an odd one now and then
  function automatic void push_point_list(ref text_t txt);
    string seps[3] = '{", ", ",", " "};
    int    points;
    points = $urandom_range(1, 4);
    push_text(txt, "[");
    for (int p = 0; p < points; p++) begin
      if (p != 0) push_text(txt, seps[$urandom_range(0, 2)]);
      push_text(txt, "[");
      push_number(txt);
      if ($urandom_range(0, 4) != 0) begin
        push_text(txt, seps[$urandom_range(0, 2)]);
        push_number(txt);
      end
      push_text(txt, "]");
    end
    push_text(txt, "]");
  endfunction

  // wait for the checker to run dry, with the character channel idle
  task automatic drain();
    char_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    text_t txt;
    int    n;
    quiet        = 1'b0;
    gap_pct      = 10;
    items_sent   = 0;
    strings_sent = 0;
    rst                  <= 1'b1;
    char_bus.valid       <= 1'b0;
    char_bus.char_code   <= '0;
    char_bus.end_of_text <= 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: lone minus and lone point at end of string
    txt = {}; push_text(txt, "-");       send_text(txt);
    txt = {}; push_text(txt, ".");       send_text(txt);
    // repeated point, minus closing a number, digit closing the string
    txt = {}; push_text(txt, "1.2.3-4"); send_text(txt);
    // byte extremes, top-half bytes skipped, a digit opening at the last byte
    txt = {8'h00, 8'h80, CHAR_NINE, 8'hff, CHAR_ZERO};
    send_text(txt);
    // signed point with no digits, then a y value
    txt = {}; push_text(txt, "-.,7");    send_text(txt);
    // second minus ends the first one on the final byte
    txt = {}; push_text(txt, "--");      send_text(txt);
    // string ending while skipping
    txt = {8'h7f};                       send_text(txt);
    drain();

    // fraction long enough to saturate the digit count
    txt = {};
    push_text(txt, "0.");
    push_digits(txt, LONG_FRACTION);
    push_text(txt, "]");
    send_text(txt);

    // random strings: mostly point lists, some noise and broken lists
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        2:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      txt = {};
      n   = $urandom_range(0, 99);
      if (n < 75) begin
        push_point_list(txt);
      end else if (n < 88) begin
        repeat ($urandom_range(1, 20)) add_char(txt, CHAR_W'($urandom_range(0, 255)));
      end else begin
        push_point_list(txt);
        txt = txt[0:$urandom_range(0, txt.size() - 1)];
        repeat ($urandom_range(1, 3))
          txt[$urandom_range(0, txt.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end
      send_text(txt);
      if (!quiet && strings_sent % 10 == 0) drain();
    end
    char_bus.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("scanned %0d characters in %0d strings, checked %0d numbers and %0d string ends",
             items_sent, strings_sent, numbers_checked, strings_checked);
    $display("covered lone signs and points, repeated points, wrapping mantissas, %0s",
             "a saturated fraction count and byte extremes");
    if (failures == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
